// ===== sv/fcfcp_pkg.sv =====
// Shared types, constants and the CRC byte update for the frame packer.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package fcfcp_pkg;

  localparam int unsigned NUM_CHANNELS = 4;
  localparam int unsigned SAMPLE_W     = 16;
  localparam int unsigned SET_W        = NUM_CHANNELS * SAMPLE_W;
  localparam int unsigned QUEUE_DEPTH  = 2;

  localparam logic [15:0] CRC_SEED = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // Byte positions within one frame.
  localparam logic [3:0] CRC_LO_IDX = 4'd8;
  localparam logic [3:0] LAST_IDX   = 4'd9;

  // Channel 0 sits in the low bits, so byte k of the payload is bits [8k+7:8k].
  typedef logic [SET_W-1:0] sample_set_t;

  typedef struct packed {
    logic        valid;
    sample_set_t data;
  } set_req_t;

  typedef struct packed {
    logic       busy;
    logic [3:0] idx;
  } back_stat_t;

  // Reflected CRC-16 update over one byte.
  function automatic logic [15:0] crc_update(input logic [15:0] acc, input logic [7:0] octet);
    logic [15:0] c;
    c = acc ^ {8'h00, octet};
    for (int b = 0; b < 8; b++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ===== sv/fcfcp_front.sv =====
// Input side: accepts sample sets and holds them in a short queue for the back end.
// Depends on fcfcp_pkg.
`timescale 1ns / 1ps

module fcfcp_front import fcfcp_pkg::*; #(
  parameter int unsigned Depth = QUEUE_DEPTH,
  localparam int unsigned PtrW = $clog2(Depth),
  localparam int unsigned CntW = $clog2(Depth + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  logic [SAMPLE_W-1:0] chan0_i,
  input  logic [SAMPLE_W-1:0] chan1_i,
  input  logic [SAMPLE_W-1:0] chan2_i,
  input  logic [SAMPLE_W-1:0] chan3_i,
  output set_req_t            req_o,
  input  logic                take_i
);

  sample_set_t     mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            wr_en, rd_en;

  assign full       = (count_q == CntW'(Depth));
  assign wr_en      = push && !full;
  assign rd_en      = take_i && (count_q != '0);
  assign req_o.valid = (count_q != '0);
  assign req_o.data  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (wr_en) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (rd_en) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (wr_en && !rd_en) begin
      count_d = count_q + 1'b1;
    end else if (rd_en && !wr_en) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= {chan3_i, chan2_i, chan1_i, chan0_i};
    end
  end

endmodule

// ===== sv/fcfcp_back.sv =====
// Output side: serializes one sample set into ten frame bytes, building the CRC
// as the payload goes out, into a single output register. Depends on fcfcp_pkg.
`timescale 1ns / 1ps

module fcfcp_back import fcfcp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  set_req_t   req_i,
  output logic       take_o,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] frame_byte_o,
  output logic       frame_end_o,
  output back_stat_t stat_o
);

  sample_set_t set_q, set_d;
  logic [15:0] crc_q, crc_d;
  logic [3:0]  idx_q, idx_d;
  logic        busy_q, busy_d;
  logic        out_valid_q, out_valid_d;
  logic [7:0]  out_byte_q, out_byte_d;
  logic        out_end_q, out_end_d;
  logic        advance, emit, last;
  logic [7:0]  cur_byte;

  assign advance = !out_valid_q || pop;
  assign emit    = busy_q && advance;
  assign last    = (idx_q == LAST_IDX);
  // Load the next set while idle, or in the same cycle the last byte leaves.
  assign take_o  = req_i.valid && (!busy_q || (last && advance));

  always_comb begin
    if (idx_q < CRC_LO_IDX) begin
      cur_byte = set_q[{idx_q[2:0], 3'b000} +: 8];
    end else if (idx_q == CRC_LO_IDX) begin
      cur_byte = crc_q[7:0];
    end else begin
      cur_byte = crc_q[15:8];
    end
  end

  always_comb begin
    set_d       = set_q;
    crc_d       = crc_q;
    idx_d       = idx_q;
    busy_d      = busy_q;
    out_valid_d = out_valid_q;
    out_byte_d  = out_byte_q;
    out_end_d   = out_end_q;
    if (emit) begin
      out_valid_d = 1'b1;
      out_byte_d  = cur_byte;
      out_end_d   = last;
      idx_d       = idx_q + 1'b1;
      if (idx_q < CRC_LO_IDX) begin
        crc_d = crc_update(crc_q, cur_byte);
      end
      if (last) begin
        busy_d = 1'b0;
      end
    end else if (pop) begin
      out_valid_d = 1'b0;
    end
    if (take_o) begin
      set_d  = req_i.data;
      crc_d  = CRC_SEED;
      idx_d  = '0;
      busy_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    set_q      <= set_d;
    crc_q      <= crc_d;
    out_byte_q <= out_byte_d;
    out_end_q  <= out_end_d;
  end

  assign empty        = !out_valid_q;
  assign frame_byte_o = out_byte_q;
  assign frame_end_o  = out_end_q;
  assign stat_o       = '{busy: busy_q, idx: idx_q};

endmodule

// ===== sv/four_channel_frame_crc16_packer_unit.sv =====
// Top level of the four-channel frame packer with CRC-16.
// Depends on fcfcp_pkg, fcfcp_front and fcfcp_back.
//
//   Channel   Direction  Handshake        Payload
//   samples   in         push / full      chan0_i..chan3_i, 16 bits each
//   frame     out        empty / pop      frame_byte_o (8), frame_end_o (1)
//
// One frame byte leaves per cycle while pop is held high; a sample set becomes ten
// frame bytes, counted by the byte counter of the serializer. The first set after idle is
// loaded before its first byte goes out; later sets load in the cycle the previous CRC high byte leaves.
// Reset clears the input queue, the serializer and the output register.
// Pop held low stalls the serializer; the input queue keeps taking sets until full.
`timescale 1ns / 1ps

module four_channel_frame_crc16_packer_unit import fcfcp_pkg::*; #(
  parameter int unsigned QueueDepth = QUEUE_DEPTH
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  logic [SAMPLE_W-1:0] chan0_i,
  input  logic [SAMPLE_W-1:0] chan1_i,
  input  logic [SAMPLE_W-1:0] chan2_i,
  input  logic [SAMPLE_W-1:0] chan3_i,
  output logic                empty,
  input  logic                pop,
  output logic [7:0]          frame_byte_o,
  output logic                frame_end_o
);

  set_req_t   set_req;
  logic       take;
  back_stat_t back_stat;

  fcfcp_front #(
    .Depth(QueueDepth)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push   (push),
    .full   (full),
    .chan0_i(chan0_i),
    .chan1_i(chan1_i),
    .chan2_i(chan2_i),
    .chan3_i(chan3_i),
    .req_o  (set_req),
    .take_i (take)
  );

  fcfcp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (set_req),
    .take_o      (take),
    .empty       (empty),
    .pop         (pop),
    .frame_byte_o(frame_byte_o),
    .frame_end_o (frame_end_o),
    .stat_o      (back_stat)
  );

`ifndef SYNTHESIS
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    back_stat.busy |-> (back_stat.idx <= LAST_IDX))
    else $error("serializer byte index out of range");

  a_idle_takes_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (set_req.valid && !back_stat.busy) |=> back_stat.busy)
    else $error("queued sample set not picked up by idle serializer");

  a_frame_done_at_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(back_stat.busy) |-> ($past(back_stat.idx) == LAST_IDX))
    else $error("serializer stopped before the CRC high byte");
`endif

endmodule

// ===== dv/tb_four_channel_frame_crc16_packer_unit.sv =====
// Testbench for the four-channel frame packer: drives sample sets, predicts each
// ten-byte frame with its CRC-16 and checks every byte popped. Depends on fcfcp_pkg.
`timescale 1ns / 1ps

module tb_four_channel_frame_crc16_packer_unit;
  import fcfcp_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } frame_byte_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] c0;
    logic [SAMPLE_W-1:0] c1;
    logic [SAMPLE_W-1:0] c2;
    logic [SAMPLE_W-1:0] c3;
    bit                  typed;
    logic [63:0]         payload;  // byte k of the frame at bits [8k+7:8k]
  } sample_row_t;

  localparam int NumRows     = 12;
  localparam int RandomSets  = 458;
  localparam int QuietSets   = 60;
  localparam int DrainCycles = 20;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                push = 1'b0;
  logic                full;
  logic [SAMPLE_W-1:0] chan0_i = '0;
  logic [SAMPLE_W-1:0] chan1_i = '0;
  logic [SAMPLE_W-1:0] chan2_i = '0;
  logic [SAMPLE_W-1:0] chan3_i = '0;
  logic                empty;
  logic                pop = 1'b0;
  logic [7:0]          frame_byte_o;
  logic                frame_end_o;

  frame_byte_t expected_bytes [$];
  sample_row_t sample_rows [NumRows];
  int          mismatch_count = 0;
  bit          quiet = 1'b0;
  int          pop_stall = 0;

  four_channel_frame_crc16_packer_unit u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .chan0_i      (chan0_i),
    .chan1_i      (chan1_i),
    .chan2_i      (chan2_i),
    .chan3_i      (chan3_i),
    .empty        (empty),
    .pop          (pop),
    .frame_byte_o (frame_byte_o),
    .frame_end_o  (frame_end_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2ms;
    $display("Timeout with %0d frame bytes outstanding", expected_bytes.size());
    $display("Some tests failed");
    $finish;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatch_count++;
    $display("%0t: %s mismatch: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
  endtask

  // Reflected CRC-16, shifted out LSB first over the eight payload bytes.
  function automatic logic [15:0] payload_crc16(input logic [63:0] payload);
    logic [15:0] acc;
    acc = CRC_SEED;
    for (int k = 0; k < 8; k++) begin
      acc = acc ^ {8'h00, payload[8*k +: 8]};
      for (int b = 0; b < 8; b++) begin
        acc = acc[0] ? ((acc >> 1) ^ CRC_POLY) : (acc >> 1);
      end
    end
    return acc;
  endfunction

  task automatic queue_frame(input logic [63:0] payload);
    logic [15:0] crc;
    logic [79:0] frame;
    crc   = payload_crc16(payload);
    frame = {crc, payload};
    for (int k = 0; k < 10; k++) begin
      expected_bytes.push_back('{data: frame[8*k +: 8], last: (k == int'(LAST_IDX))});
    end
  endtask

  // Hold the set on the ports until the input queue accepts it.
  task automatic send_set(input logic [SAMPLE_W-1:0] a, input logic [SAMPLE_W-1:0] b,
                          input logic [SAMPLE_W-1:0] c, input logic [SAMPLE_W-1:0] d,
                          input logic [63:0] payload);
    chan0_i <= a;
    chan1_i <= b;
    chan2_i <= c;
    chan3_i <= d;
    push    <= 1'b1;
    do @(posedge clk_i); while (full);
    queue_frame(payload);
  endtask

  task automatic sender_gap();
    if (!quiet && $urandom_range(0, 3) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  endtask

  task automatic drain_frames();
    push <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    logic [SAMPLE_W-1:0] one_hot;
    one_hot = 16'h0001 << $urandom_range(0, 15);
    case ($urandom_range(0, 9))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return one_hot;
      3:       return ~one_hot;
      default: return 16'($urandom);
    endcase
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pop && !empty) begin
        if (expected_bytes.size() == 0) begin
          report_mismatch("unexpected frame byte", int'(frame_byte_o), 0);
        end else begin
          if (frame_byte_o !== expected_bytes[0].data) begin
            report_mismatch("frame_byte", int'(frame_byte_o),
                            int'(expected_bytes[0].data));
          end
          if (frame_end_o !== expected_bytes[0].last) begin
            report_mismatch("frame_end", int'(frame_end_o), int'(expected_bytes[0].last));
          end
          void'(expected_bytes.pop_front());
        end
      end
      if (pop_stall > 0) begin
        pop_stall--;
        pop <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        pop_stall = $urandom_range(1, 12) - 1;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  initial begin
    logic [SAMPLE_W-1:0] s0, s1, s2, s3;

    // Typed payloads are the channel bytes, low byte first, channel 0 first.
    sample_rows[0]  = '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1, 64'h0000_0000_0000_0000};
    sample_rows[1]  = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF};
    sample_rows[2]  = '{16'h00FF, 16'hFF00, 16'h00FF, 16'hFF00, 1'b1, 64'hFF00_00FF_FF00_00FF};
    sample_rows[3]  = '{16'h0001, 16'h8000, 16'h0001, 16'h8000, 1'b1, 64'h8000_0001_8000_0001};
    sample_rows[4]  = '{16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 1'b1, 64'hAAAA_5555_AAAA_5555};
    sample_rows[5]  = '{16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0, 1'b1, 64'hDEF0_9ABC_5678_1234};
    sample_rows[6]  = '{16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 1'b1, 64'h0000_0000_0000_FFFF};
    sample_rows[7]  = '{16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 1'b1, 64'hFFFF_0000_0000_0000};
    sample_rows[8]  = '{16'h0001, 16'h0002, 16'h0004, 16'h0008, 1'b0, 64'h0};
    sample_rows[9]  = '{16'h7FFF, 16'h8000, 16'hFFFE, 16'h0001, 1'b0, 64'h0};
    sample_rows[10] = '{16'h0100, 16'h0080, 16'hFEFF, 16'hFF7F, 1'b0, 64'h0};
    sample_rows[11] = '{16'hA5A5, 16'h5A5A, 16'hC33C, 16'h3CC3, 1'b0, 64'h0};

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (sample_rows[i]) begin
      send_set(sample_rows[i].c0, sample_rows[i].c1, sample_rows[i].c2, sample_rows[i].c3,
               sample_rows[i].typed ? sample_rows[i].payload
                                    : {sample_rows[i].c3, sample_rows[i].c2,
                                       sample_rows[i].c1, sample_rows[i].c0});
      sender_gap();
    end

    // Let the block go idle so the next set starts from an empty pipeline.
    drain_frames();
    repeat ($urandom_range(1, 12)) @(posedge clk_i);

    for (int n = 0; n < RandomSets; n++) begin
      if (n == RandomSets / 2) begin
        drain_frames();
      end
      if (n == RandomSets - QuietSets) begin
        quiet = 1'b1;
      end
      s0 = pick_sample();
      s1 = pick_sample();
      s2 = pick_sample();
      s3 = pick_sample();
      send_set(s0, s1, s2, s3, {s3, s2, s1, s0});
      sender_gap();
    end

    drain_frames();
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/fcfcp_pkg.sv
sv/fcfcp_front.sv
sv/fcfcp_back.sv
sv/four_channel_frame_crc16_packer_unit.sv
dv/tb_four_channel_frame_crc16_packer_unit.sv
